>>> design/dii_pkg.sv
// package for the decimated integral image block
// holds sizing constants, register indexes and the control state type
// no dependencies
package dii_pkg;

    // line store depth, decimation factor and height cap
    localparam int MAX_WIDTH  = 512;
    localparam int DECIMATION = 2;
    localparam int HEIGHT_CAP = 512;

    // field widths
    localparam int CFG_W   = 10;
    localparam int LUMA_W  = 8;
    localparam int OUT_W   = 28;
    localparam int STORE_W = 29;
    localparam int SUM_W   = 19;
    localparam int WT_W    = 10;

    // derived widths
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int XW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int YW  = CFG_W;
    localparam int PW  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int IDX_W = 2;

    // chroma weight
    localparam int CHROMA_GAIN = 3;

    // register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(240);

    // register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

    // control state
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

>>> design/decimated_integral_image.sv
// decimated integral image: weighted luma/chroma summed-area table
// line store of integral values in a one-port-read, one-port-write memory
// depends on dii_pkg
//
// a kept sample's result passes the read stage, then the output register; while
// results are taken, one sample per cycle, set by the store's read-modify-write
// reset (synchronous, active low): registers return to 320 by 240, counters clear,
// then a clearing pass zeroes the line store, one entry a cycle, all MAX_WIDTH
// (512) entries, during which no sample is taken; configuration writes still go
module decimated_integral_image
    import dii_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // sample input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [LUMA_W-1:0]  i_luma,
    input  logic [LUMA_W-1:0]  i_chroma,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OUT_W-1:0]   o_integral_value,
    output logic               o_frame_done
);

    localparam logic [PW-1:0] PH_LAST = PW'(DECIMATION - 1);

    // control and configuration
    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic                clearing;
    logic [CFG_W-1:0]    r_cfg_width, r_cfg_height;

    // position counters
    logic [XW-1:0]       r_x;
    logic [PW-1:0]       r_xp;
    logic [YW-1:0]       r_y;
    logic [PW-1:0]       r_yp;
    logic [SUM_W-1:0]    r_row_sum;

    // read stage
    logic                r_s1_valid;
    logic [AW-1:0]       r_s1_x;
    logic                r_s1_top;
    logic [SUM_W-1:0]    r_s1_sum;
    logic                r_s1_done;
    logic                r_s1_fwd;
    logic [STORE_W-1:0]  r_fwd_val;

    // output register
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_value;
    logic                r_out_done;

    // line store
    logic [STORE_W-1:0]  mem [MAX_WIDTH];
    logic [STORE_W-1:0]  r_rdata;

    // combinational
    logic [XW-1:0]       cfg_w_ext, w_eff;
    logic [YW-1:0]       h_eff;
    logic                col_wrap, last_col;
    logic [XW-1:0]       x_a;
    logic [PW-1:0]       xp_a, yp_a, yp_c;
    logic [YW:0]         y_c;
    logic [YW-1:0]       y_a;
    logic [XW-1:0]       n_x;
    logic [PW-1:0]       n_xp, n_yp;
    logic [YW-1:0]       n_y;
    logic [YW:0]         y_d;
    logic [PW-1:0]       yp_d;
    logic                keep, accept, take, s1_adv, s1_fwd;
    logic [WT_W-1:0]     weighted;
    logic [SUM_W-1:0]    sum_new;
    logic [STORE_W-1:0]  above, s1_value;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [STORE_W-1:0]  wr_data;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == AW'(MAX_WIDTH - 1)) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    // effective frame size, out-of-range values clamped
    always_comb begin
        cfg_w_ext = XW'(r_cfg_width);
        if (cfg_w_ext == '0) begin
            w_eff = XW'(1);
        end else if (cfg_w_ext > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w_ext;
        end
        if (r_cfg_height == '0) begin
            h_eff = YW'(1);
        end else if (r_cfg_height > YW'(HEIGHT_CAP)) begin
            h_eff = YW'(HEIGHT_CAP);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    // position before use: wrap a stale column, then a stale row
    always_comb begin
        col_wrap = (r_x >= w_eff);
        x_a  = col_wrap ? '0 : r_x;
        xp_a = col_wrap ? '0 : r_xp;
        if (col_wrap && (r_yp == PH_LAST)) begin
            y_c  = {1'b0, r_y} + 1'b1;
            yp_c = '0;
        end else if (col_wrap) begin
            y_c  = {1'b0, r_y};
            yp_c = r_yp + 1'b1;
        end else begin
            y_c  = {1'b0, r_y};
            yp_c = r_yp;
        end
        if (y_c >= {1'b0, h_eff}) begin
            y_a  = '0;
            yp_a = '0;
        end else begin
            y_a  = y_c[YW-1:0];
            yp_a = yp_c;
        end
        keep = (xp_a == '0) && (yp_a == '0);
    end

    // position after the sample
    always_comb begin
        last_col = (xp_a == PH_LAST) && (x_a == w_eff - 1'b1);
        if (yp_a == PH_LAST) begin
            y_d  = {1'b0, y_a} + 1'b1;
            yp_d = '0;
        end else begin
            y_d  = {1'b0, y_a};
            yp_d = yp_a + 1'b1;
        end
        if (last_col) begin
            n_x  = '0;
            n_xp = '0;
            if (y_d >= {1'b0, h_eff}) begin
                n_y  = '0;
                n_yp = '0;
            end else begin
                n_y  = y_d[YW-1:0];
                n_yp = yp_d;
            end
        end else begin
            if (xp_a == PH_LAST) begin
                n_x  = x_a + 1'b1;
                n_xp = '0;
            end else begin
                n_x  = x_a;
                n_xp = xp_a + 1'b1;
            end
            n_y  = y_a;
            n_yp = yp_a;
        end
    end

    // weighted sample and running row sum
    always_comb begin
        weighted = WT_W'(i_luma) + WT_W'(i_chroma) * WT_W'(CHROMA_GAIN);
        sum_new  = ((x_a == '0) ? '0 : r_row_sum) + SUM_W'(weighted);
    end

    // handshakes
    always_comb begin
        take        = i_out_ready || !r_out_valid;
        s1_adv      = r_s1_valid && take;
        o_in_ready  = !clearing && (!r_s1_valid || s1_adv);
        accept      = i_in_valid && o_in_ready;
        o_cfg_ready = 1'b1;
        s1_fwd      = s1_adv && (r_s1_x == x_a[AW-1:0]);
    end

    // integral value from the read stage, forwarding a same-cycle write
    always_comb begin
        if (r_s1_top) begin
            above = '0;
        end else if (r_s1_fwd) begin
            above = r_fwd_val;
        end else begin
            above = r_rdata;
        end
        s1_value = STORE_W'(r_s1_sum) + above;
    end

    // line store write port: clearing pass or write-back
    always_comb begin
        wr_en   = clearing || s1_adv;
        wr_addr = clearing ? r_clr_addr : r_s1_x;
        wr_data = clearing ? '0 : s1_value;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (accept && keep) begin
            r_rdata <= mem[x_a[AW-1:0]];
        end
    end

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_x          <= '0;
            r_xp         <= '0;
            r_y          <= '0;
            r_yp         <= '0;
            r_row_sum    <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_WIDTH) begin
                    r_cfg_width <= i_cfg_data;
                end else if (i_cfg_index == REG_HEIGHT) begin
                    r_cfg_height <= i_cfg_data;
                end
            end
            if (accept) begin
                r_x  <= n_x;
                r_xp <= n_xp;
                r_y  <= n_y;
                r_yp <= n_yp;
                if (keep) begin
                    r_row_sum <= sum_new;
                end
            end
            if (accept && keep) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_s1_x    <= x_a[AW-1:0];
            r_s1_top  <= (y_a == '0);
            r_s1_sum  <= sum_new;
            r_s1_done <= (x_a == w_eff - 1'b1) && (y_a == h_eff - 1'b1);
            r_s1_fwd  <= s1_fwd;
            r_fwd_val <= s1_value;
        end
        if (s1_adv) begin
            r_out_value <= s1_value[OUT_W-1:0];
            r_out_done  <= r_s1_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_integral_value = r_out_value;
    assign o_frame_done     = r_out_done;

endmodule

>>> tb/decimated_integral_image_checker.sv
`timescale 1ns / 100ps
// checker for decimated_integral_image: watches the three channels, predicts
// every integral value from the accepted samples and compares field by field
// depends on dii_pkg
module decimated_integral_image_checker
    import dii_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration channel
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // sample channel
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [LUMA_W-1:0] i_luma,
    input  logic [LUMA_W-1:0] i_chroma,
    // result channel
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [OUT_W-1:0]  i_integral_value,
    input  logic              i_frame_done,
    // status for the top
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             done;
    } t_integral_result;

    // own copy of the registers and the block state
    logic [CFG_W-1:0]   cols_cfg;
    logic [CFG_W-1:0]   rows_cfg;
    logic [STORE_W-1:0] prev_row_sums [MAX_WIDTH];
    logic [SUM_W-1:0]   row_acc;
    logic [11:0]        col_cnt;
    logic [11:0]        row_cnt;

    t_integral_result expected_sums [$];
    int waiting    = 0;
    int mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // register value as the block uses it: zero counts as one, large values clip
    function automatic logic [11:0] clamp_size(input logic [CFG_W-1:0] raw, input int cap);
        if (raw == '0)
            return 12'd1;
        if (int'(raw) > cap)
            return 12'(cap);
        return 12'(raw);
    endfunction

    // one accepted sample: advance the raster position, queue a value if kept
    task automatic predict_sample(input logic [LUMA_W-1:0] luma,
                                  input logic [LUMA_W-1:0] chroma);
        logic [11:0]        w;
        logic [11:0]        h;
        logic [11:0]        cols;
        logic [11:0]        rows;
        logic [11:0]        x;
        logic [11:0]        y;
        logic [STORE_W-1:0] above;
        logic [STORE_W-1:0] total;
        t_integral_result   res;
        w    = clamp_size(cols_cfg, MAX_WIDTH);
        h    = clamp_size(rows_cfg, HEIGHT_CAP);
        cols = 12'(w * DECIMATION);
        rows = 12'(h * DECIMATION);
        // counters left beyond a shrunken frame wrap before use
        if (col_cnt >= cols) begin
            col_cnt = '0;
            row_cnt = row_cnt + 12'd1;
        end
        if (row_cnt >= rows)
            row_cnt = '0;
        // only every decimated column of every decimated row is kept
        if ((col_cnt % DECIMATION) == 0 && (row_cnt % DECIMATION) == 0) begin
            x = 12'(col_cnt / DECIMATION);
            y = 12'(row_cnt / DECIMATION);
            if (x == 0)
                row_acc = '0;
            row_acc = SUM_W'(row_acc + luma + CHROMA_GAIN * chroma);
            above = (y == 0) ? '0 : prev_row_sums[x];
            total = STORE_W'(row_acc + above);
            prev_row_sums[x] = total;
            res.value = total[OUT_W-1:0];
            res.done  = (x == w - 12'd1) && (y == h - 12'd1);
            expected_sums = {expected_sums, res};
            waiting++;
        end
        // step along the raster, wrapping at line and frame end
        col_cnt = col_cnt + 12'd1;
        if (col_cnt >= cols) begin
            col_cnt = '0;
            row_cnt = row_cnt + 12'd1;
            if (row_cnt >= rows)
                row_cnt = '0;
        end
    endtask

    // sample every transfer on the clock edge
    always @(posedge i_clk) begin : watch
        t_integral_result want;
        if (!i_rst_n) begin
            cols_cfg = WIDTH_RESET;
            rows_cfg = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
                prev_row_sums[i] = '0;
            row_acc = '0;
            col_cnt = '0;
            row_cnt = '0;
            expected_sums.delete();
            waiting = 0;
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WIDTH)
                    cols_cfg = i_cfg_data;
                else if (i_cfg_index == REG_HEIGHT)
                    rows_cfg = i_cfg_data;
            end
            // sample transfer
            if (i_in_valid && i_in_ready)
                predict_sample(i_luma, i_chroma);
            // result transfer against the oldest expected value
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected result: integral_value %0d, frame_done %0b",
                           i_integral_value, i_frame_done);
                    mismatches++;
                end else begin
                    want = expected_sums.pop_front();
                    waiting--;
                    if (want.value !== i_integral_value) begin
                        $error("integral_value: expected %0d, actual %0d",
                               want.value, i_integral_value);
                        mismatches++;
                    end
                    if (want.done !== i_frame_done) begin
                        $error("frame_done: expected %0b, actual %0b",
                               want.done, i_frame_done);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/decimated_integral_image_tb.sv
`timescale 1ns / 100ps
// testbench top for decimated_integral_image: clock, reset, stimulus and verdict
// depends on dii_pkg, decimated_integral_image and decimated_integral_image_checker
module decimated_integral_image_tb;
    import dii_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 150;

    // indexes with no register behind them
    localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_PATTERN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [LUMA_W-1:0]  i_luma;
    logic [LUMA_W-1:0]  i_chroma;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [OUT_W-1:0]   o_integral_value;
    logic               o_frame_done;

    int fail_count;
    int pending_sums;
    int burst_left     = 0;
    int idle_cycles    = 0;
    bit long_stall_req = 1'b0;

    decimated_integral_image dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_luma           (i_luma),
        .i_chroma         (i_chroma),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_integral_value (o_integral_value),
        .o_frame_done     (o_frame_done)
    );

    decimated_integral_image_checker sum_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_luma           (i_luma),
        .i_chroma         (i_chroma),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_integral_value (o_integral_value),
        .i_frame_done     (o_frame_done),
        .o_fail_count     (fail_count),
        .o_pending        (pending_sums)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("decimated_integral_image_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: a random stall pattern, switched to another at random,
    // plus one long hold-off on request
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       pattern_cnt;
        mode        = RX_STEADY;
        mode_left   = 0;
        pattern_cnt = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                pattern_cnt++;
                case (mode)
                    RX_STEADY:  i_out_ready <= 1'b1;
                    RX_PATTERN: i_out_ready <= (pattern_cnt % 3) != 2;
                    RX_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
                    default:    i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // sample values leaning towards the extremes now and then
    function automatic logic [LUMA_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LUMA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // frame sizes: mostly tiny, sometimes zero, now and then large
    function automatic logic [CFG_W-1:0] random_size();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_W'($urandom_range(300, 1023));
            2:       return CFG_W'(MAX_WIDTH);
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // one register transfer, valid left high for a following write
    task automatic cfg_transfer(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_transfer(REG_WIDTH, w);
        cfg_transfer(REG_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // one sample transfer; bursts of random length with random gaps between
    task automatic send_sample(input logic [LUMA_W-1:0] luma, input logic [LUMA_W-1:0] chroma);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_luma     <= luma;
        i_chroma   <= chroma;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drain: all expected values back, then let dropped samples clear the pipeline
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int               n;
        int               sent;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_luma      <= '0;
        i_chroma    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 2 x 2 frame, extreme samples on the kept positions
        set_frame_size(CFG_W'(2), CFG_W'(2));
        for (int i = 0; i < 16; i++) begin
            case (i)
                0:       send_sample('1, '1);
                2:       send_sample('0, '0);
                8:       send_sample('1, '0);
                10:      send_sample('0, '1);
                default: send_sample(random_sample(), random_sample());
            endcase
        end

        // zero sizes count as one, so every fourth sample closes a frame;
        // writes to unused indexes must change nothing
        wait_idle();
        cfg_transfer(REG_SPARE_2, '1);
        cfg_transfer(REG_SPARE_3, '1);
        set_frame_size('0, '0);
        repeat (8) send_sample(random_sample(), random_sample());

        // oversized width clips to the line store depth: one full kept row,
        // then a few samples into the dropped row after it
        wait_idle();
        set_frame_size('1, '0);
        repeat (1030) send_sample(random_sample(), random_sample());

        // oversized height: single column, rows run on past the usual sizes
        wait_idle();
        set_frame_size('0, '1);
        repeat (24) send_sample(random_sample(), random_sample());

        // random phases; lengths rarely match the frame so sizes change mid-frame
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 7) == 0)
                cfg_transfer(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                             CFG_W'($urandom));
            w = random_size();
            h = random_size();
            set_frame_size(w, h);
            if (sent == 0) begin
                // long receiver hold-off while samples keep coming
                n = 60;
                long_stall_req = 1'b1;
            end else begin
                n = $urandom_range(1, 40);
            end
            repeat (n) send_sample(random_sample(), random_sample());
            sent += n;
        end

        wait_idle();
        if (fail_count == 0 && pending_sums == 0)
            $display("decimated_integral_image_tb passed");
        else
            $display("decimated_integral_image_tb failed");
        $finish;
    end

endmodule

>>> decimated_integral_image.f
design/dii_pkg.sv
design/decimated_integral_image.sv
tb/decimated_integral_image_checker.sv
tb/decimated_integral_image_tb.sv
